>>> hw/rtl/rtfd_pkg.sv
// rtfd_pkg: shared types, constants and the shade lookup for the
// run-length text frame decoder. No dependencies.
package rtfd_pkg;

  // field widths
  localparam int CODE_W     = 8;
  localparam int SHADE_BITS = 3;
  localparam int RUN_W      = CODE_W - SHADE_BITS;
  localparam int CHAR_W     = 8;
  localparam int CELL_W     = 13;
  localparam int COL_W      = 7;
  localparam int ROW_W      = 6;

  // configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int COLS_W     = 8;
  localparam int ROWS_W     = 7;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROWS    = CFG_IDX_W'(1);
  localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);
  localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(25);

  // size limits and command queue depth
  localparam int DEF_MAX_COLUMNS = 128;
  localparam int DEF_MAX_ROWS    = 64;
  localparam int CMD_DEPTH       = 2;

  // command from front to back
  typedef struct packed {
    logic              halt;
    logic [RUN_W-1:0]  run;
    logic [CHAR_W-1:0] char_code;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  // shade character for a 3-bit index: " .:+=#%@"
  function automatic logic [CHAR_W-1:0] shade_char(input logic [SHADE_BITS-1:0] idx);
    logic [CHAR_W-1:0] c;
    unique case (idx)
      3'd0: c = 8'h20;
      3'd1: c = 8'h2E;
      3'd2: c = 8'h3A;
      3'd3: c = 8'h2B;
      3'd4: c = 8'h3D;
      3'd5: c = 8'h23;
      3'd6: c = 8'h25;
      3'd7: c = 8'h40;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

endpackage

>>> hw/rtl/rtfd_front.sv
// rtfd_front: takes code bytes, splits run and shade, turns a zero run into
// a halt command and drops every byte after it. Depends on rtfd_pkg.
module rtfd_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  input  logic [rtfd_pkg::CODE_W-1:0] in_code_byte,
  output logic                        in_full,
  input  logic                        q_full,
  output logic                        q_push,
  output rtfd_pkg::cmd_t              q_cmd
);

  logic stopped_r, stopped_nxt;
  logic accept;

  // input transfer and classification
  always_comb begin
    accept            = in_push && !q_full;
    q_cmd.run         = in_code_byte[rtfd_pkg::CODE_W-1:rtfd_pkg::SHADE_BITS];
    q_cmd.halt        = (q_cmd.run == '0);
    q_cmd.char_code   = rtfd_pkg::shade_char(in_code_byte[rtfd_pkg::SHADE_BITS-1:0]);
    q_push            = accept && !stopped_r;
    in_full           = q_full;
    stopped_nxt       = stopped_r || (q_push && q_cmd.halt);
  end

  // halt flag, cleared only by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= 1'b0;
    end else begin
      stopped_r <= stopped_nxt;
    end
  end

  a_stop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    stopped_r |=> stopped_r && !q_push)
    else $error("halt flag dropped or command queued after halt");

endmodule

>>> hw/rtl/rtfd_cmd_fifo.sv
// rtfd_cmd_fifo: short command queue between front and back.
// Depends on rtfd_pkg for the command type.
module rtfd_cmd_fifo #(
  parameter int DEPTH = rtfd_pkg::CMD_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  rtfd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           pop,
  output rtfd_pkg::cmd_t rd_cmd,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rtfd_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  // pointer and count update
  always_comb begin
    full       = (count_r == CNT_W'(DEPTH));
    empty      = (count_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    rd_cmd    = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("command queue count beyond depth");

endmodule

>>> hw/rtl/rtfd_back.sv
// rtfd_back: expands commands into cell writes, walks the cursor and holds
// the result register. Depends on rtfd_pkg.
module rtfd_back #(
  parameter int CLAMP_COLS_W = 8,
  parameter int CLAMP_ROWS_W = 7
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [CLAMP_COLS_W-1:0]       cols,
  input  logic [CLAMP_ROWS_W-1:0]       rows,
  input  logic                          q_empty,
  input  rtfd_pkg::cmd_t                q_cmd,
  output logic                          q_pop,
  output logic                          out_empty,
  input  logic                          out_pop,
  output logic [rtfd_pkg::CELL_W-1:0]   out_cell_index,
  output logic [rtfd_pkg::CHAR_W-1:0]   out_char_code,
  output logic                          out_frame_done,
  output logic                          out_last,
  output logic                          out_halted
);

  rtfd_pkg::back_state_t state_r, state_nxt;

  logic [rtfd_pkg::RUN_W-1:0]  rem_r;
  logic [rtfd_pkg::CHAR_W-1:0] ch_r;
  logic [rtfd_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [rtfd_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic                        out_valid_r;
  logic [rtfd_pkg::CELL_W-1:0] cell_r;
  logic [rtfd_pkg::CHAR_W-1:0] char_r;
  logic                        done_r, last_r, halted_r;

  logic                        from_head, cur_valid, slot_free, emit;
  logic                        cur_halt, is_last;
  logic [rtfd_pkg::RUN_W-1:0]  cur_rem;
  logic [rtfd_pkg::CHAR_W-1:0] cur_char;
  logic [rtfd_pkg::CELL_W-1:0] cell_idx;
  logic [rtfd_pkg::COL_W-1:0]  col_inc;
  logic [rtfd_pkg::ROW_W-1:0]  row_inc, row_step;
  logic                        col_wrap, frame_end;

  // current command: queue head when idle, held command while running
  always_comb begin
    from_head = (state_r == rtfd_pkg::BK_IDLE);
    cur_valid = !from_head || !q_empty;
    slot_free = !out_valid_r || out_pop;
    emit      = cur_valid && slot_free;
    cur_halt  = from_head && q_cmd.halt;
    cur_rem   = from_head ? q_cmd.run : rem_r;
    cur_char  = from_head ? q_cmd.char_code : ch_r;
    is_last   = (cur_rem == rtfd_pkg::RUN_W'(1));
    q_pop     = emit && from_head;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rtfd_pkg::BK_IDLE: begin
        if (emit && !cur_halt && !is_last) begin
          state_nxt = rtfd_pkg::BK_RUN;
        end
      end
      rtfd_pkg::BK_RUN: begin
        if (emit && is_last) begin
          state_nxt = rtfd_pkg::BK_IDLE;
        end
      end
      default: state_nxt = rtfd_pkg::BK_IDLE;
    endcase
  end

  // cell address and cursor walk
  always_comb begin
    cell_idx  = rtfd_pkg::CELL_W'(row_r) * rtfd_pkg::CELL_W'(cols)
              + rtfd_pkg::CELL_W'(col_r);
    col_inc   = col_r + 1'b1;
    row_inc   = row_r + 1'b1;
    col_wrap  = (col_inc == '0) || (32'(col_inc) >= 32'(cols));
    row_step  = col_wrap ? row_inc : row_r;
    frame_end = (col_wrap && (row_inc == '0)) || (32'(row_step) >= 32'(rows));
    if (frame_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else begin
      col_nxt = col_wrap ? '0 : col_inc;
      row_nxt = row_step;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rtfd_pkg::BK_IDLE;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit && !cur_halt) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // run payload and result register
  always_ff @(posedge clk) begin
    if (emit) begin
      rem_r    <= cur_rem - 1'b1;
      ch_r     <= cur_char;
      halted_r <= cur_halt;
      last_r   <= cur_halt || is_last;
      cell_r   <= cur_halt ? '0 : cell_idx;
      char_r   <= cur_halt ? '0 : cur_char;
      done_r   <= !cur_halt && frame_end;
    end
  end

  assign out_empty      = !out_valid_r;
  assign out_cell_index = cell_r;
  assign out_char_code  = char_r;
  assign out_frame_done = done_r;
  assign out_last       = last_r;
  assign out_halted     = halted_r;

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtfd_pkg::BK_RUN |-> rem_r != '0)
    else $error("running with no cells left");

  a_head_run: assert property (@(posedge clk) disable iff (!rst_n)
    !q_empty && !q_cmd.halt |-> q_cmd.run != '0)
    else $error("zero run command not marked halt");

  a_halt_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && halted_r |-> cell_r == '0 && char_r == '0 && !done_r && last_r)
    else $error("halted result carries cell data");

  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rtfd_pkg::BK_RUN && emit && is_last |=> state_r == rtfd_pkg::BK_IDLE)
    else $error("run did not end after its last cell");

endmodule

>>> hw/rtl/rle_text_frame_decoder.sv
// rle_text_frame_decoder: top level; config registers, size clamp, front,
// command queue and back. Depends on rtfd_pkg, rtfd_front, rtfd_cmd_fifo, rtfd_back.
//
//   channel  | direction | handshake         | payload
//   in_      | in        | push / full       | code_byte[7:0]
//   out_     | out       | empty / pop       | cell_index, char_code, frame_done,
//            |           |                   | last, halted
//   cfg_     | in        | we (no wait)      | index[1:0], wdata[7:0]
//
// A byte with run length n (1 to 31) gives n cell writes in the back end, one cell
// write per cycle while the result register takes them; a zero run gives a single
// halt result. Reset is synchronous, active low, and clears cursor, halt flag,
// queue and result register; sizes return to 80 by 25. A stalled result
// register stalls the back end; the two-entry command queue lets the front
// keep accepting bytes until it fills.
module rle_text_frame_decoder #(
  parameter int MAX_COLUMNS = rtfd_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = rtfd_pkg::DEF_MAX_ROWS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_push,
  input  logic [rtfd_pkg::CODE_W-1:0]     in_code_byte,
  output logic                            in_full,
  output logic                            out_empty,
  input  logic                            out_pop,
  output logic [rtfd_pkg::CELL_W-1:0]     out_cell_index,
  output logic [rtfd_pkg::CHAR_W-1:0]     out_char_code,
  output logic                            out_frame_done,
  output logic                            out_last,
  output logic                            out_halted,
  input  logic                            cfg_we,
  input  logic [rtfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rtfd_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CLAMP_COLS_W = $clog2(MAX_COLUMNS + 1);
  localparam int CLAMP_ROWS_W = $clog2(MAX_ROWS + 1);

  logic [rtfd_pkg::COLS_W-1:0] cols_r;
  logic [rtfd_pkg::ROWS_W-1:0] rows_r;
  logic [CLAMP_COLS_W-1:0]     cols_c;
  logic [CLAMP_ROWS_W-1:0]     rows_c;

  logic           q_push, q_full, q_pop, q_empty;
  rtfd_pkg::cmd_t q_wr_cmd, q_rd_cmd;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= rtfd_pkg::COLS_RESET;
      rows_r <= rtfd_pkg::ROWS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtfd_pkg::REG_COLUMNS: cols_r <= cfg_wdata[rtfd_pkg::COLS_W-1:0];
        rtfd_pkg::REG_ROWS:    rows_r <= cfg_wdata[rtfd_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes to 1..max
  always_comb begin
    if (cols_r == '0) begin
      cols_c = CLAMP_COLS_W'(1);
    end else if (32'(cols_r) > MAX_COLUMNS) begin
      cols_c = CLAMP_COLS_W'(MAX_COLUMNS);
    end else begin
      cols_c = CLAMP_COLS_W'(cols_r);
    end
    if (rows_r == '0) begin
      rows_c = CLAMP_ROWS_W'(1);
    end else if (32'(rows_r) > MAX_ROWS) begin
      rows_c = CLAMP_ROWS_W'(MAX_ROWS);
    end else begin
      rows_c = CLAMP_ROWS_W'(rows_r);
    end
  end

  rtfd_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_code_byte (in_code_byte),
    .in_full      (in_full),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (q_wr_cmd)
  );

  rtfd_cmd_fifo #(
    .DEPTH (rtfd_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_cmd (q_wr_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_rd_cmd),
    .empty  (q_empty)
  );

  rtfd_back #(
    .CLAMP_COLS_W (CLAMP_COLS_W),
    .CLAMP_ROWS_W (CLAMP_ROWS_W)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cols           (cols_c),
    .rows           (rows_c),
    .q_empty        (q_empty),
    .q_cmd          (q_rd_cmd),
    .q_pop          (q_pop),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_cell_index (out_cell_index),
    .out_char_code  (out_char_code),
    .out_frame_done (out_frame_done),
    .out_last       (out_last),
    .out_halted     (out_halted)
  );

endmodule

>>> dv/tb_rle_text_frame_decoder.sv
// tb_rle_text_frame_decoder: self-checking testbench for the run-length text frame decoder.
// Code bytes go in, and each cell write that comes out is checked against a local cursor model.
// Depends on rtfd_pkg and rle_text_frame_decoder.
module tb_rle_text_frame_decoder;

  localparam int SCREEN_MAX_COLS   = 128;
  localparam int SCREEN_MAX_ROWS   = 64;
  localparam int COLS_AFTER_RESET  = 80;
  localparam int ROWS_AFTER_RESET  = 25;
  localparam int SETTLE_CYCLES     = 80;
  localparam int QUIET_LIMIT       = 4000;
  localparam int RANDOM_PHASES     = 6;
  localparam int ITEMS_PER_PHASE   = 40;
  localparam logic [rtfd_pkg::CFG_IDX_W-1:0] REG_SPARE2 = rtfd_pkg::CFG_IDX_W'(2);
  localparam logic [rtfd_pkg::CFG_IDX_W-1:0] REG_SPARE3 = rtfd_pkg::CFG_IDX_W'(3);
  localparam logic [rtfd_pkg::CODE_W-1:0]    CODE_HALT  = '0;

  // shade characters by index
  localparam logic [rtfd_pkg::CHAR_W-1:0] SHADE_LUT [8] = '{
    8'h20, 8'h2E, 8'h3A, 8'h2B, 8'h3D, 8'h23, 8'h25, 8'h40
  };

  typedef struct packed {
    logic [rtfd_pkg::CELL_W-1:0] cell_index;
    logic [rtfd_pkg::CHAR_W-1:0] char_code;
    logic                        frame_done;
    logic                        last;
    logic                        halted;
  } cell_write_t;

  logic                            clk;
  logic                            rst_n = 1'b0;
  logic                            in_push = 1'b0;
  logic [rtfd_pkg::CODE_W-1:0]     in_code_byte = '0;
  logic                            in_full;
  logic                            out_empty;
  logic                            out_pop = 1'b0;
  logic [rtfd_pkg::CELL_W-1:0]     out_cell_index;
  logic [rtfd_pkg::CHAR_W-1:0]     out_char_code;
  logic                            out_frame_done;
  logic                            out_last;
  logic                            out_halted;
  logic                            cfg_we = 1'b0;
  logic [rtfd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rtfd_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  // cursor model state and register copies
  logic [rtfd_pkg::COL_W-1:0]  cursor_col = '0;
  logic [rtfd_pkg::ROW_W-1:0]  cursor_row = '0;
  logic                        decoder_stopped = 1'b0;
  logic [rtfd_pkg::COLS_W-1:0] columns_reg = rtfd_pkg::COLS_W'(COLS_AFTER_RESET);
  logic [rtfd_pkg::ROWS_W-1:0] rows_reg = rtfd_pkg::ROWS_W'(ROWS_AFTER_RESET);

  cell_write_t pending_writes[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          pop_hold = 0;
  bit          idle_on = 1'b0;

  rle_text_frame_decoder #(
    .MAX_COLUMNS(SCREEN_MAX_COLS),
    .MAX_ROWS(SCREEN_MAX_ROWS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_code_byte(in_code_byte),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_cell_index(out_cell_index),
    .out_char_code(out_char_code),
    .out_frame_done(out_frame_done),
    .out_last(out_last),
    .out_halted(out_halted),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [rtfd_pkg::CODE_W-1:0] code_of(input int unsigned run,
                                                          input int unsigned shade);
    return {rtfd_pkg::RUN_W'(run), rtfd_pkg::SHADE_BITS'(shade)};
  endfunction

  // expand one accepted code byte into the cell writes it should produce
  function automatic void expand_code(input logic [rtfd_pkg::CODE_W-1:0] code);
    logic [rtfd_pkg::RUN_W-1:0] run;
    int unsigned                cols;
    int unsigned                rows;
    int unsigned                k;
    logic                       row_wrapped;
    cell_write_t                w;
    run  = code[rtfd_pkg::CODE_W-1:rtfd_pkg::SHADE_BITS];
    cols = (columns_reg == 0) ? 1 : (columns_reg > SCREEN_MAX_COLS) ? SCREEN_MAX_COLS
                                                                    : columns_reg;
    rows = (rows_reg == 0) ? 1 : (rows_reg > SCREEN_MAX_ROWS) ? SCREEN_MAX_ROWS : rows_reg;
    if (decoder_stopped) return;
    // zero run: single halt marker, then everything is dropped
    if (run == 0) begin
      decoder_stopped = 1'b1;
      w = '0;
      w.last = 1'b1;
      w.halted = 1'b1;
      pending_writes.push_back(w);
      return;
    end
    for (k = 0; k < run; k++) begin
      w = '0;
      w.cell_index = rtfd_pkg::CELL_W'(cursor_row * cols + cursor_col);
      w.char_code = SHADE_LUT[code[rtfd_pkg::SHADE_BITS-1:0]];
      row_wrapped = 1'b0;
      cursor_col = cursor_col + 1'b1;
      // column wraps on reaching the width or on counter rollover
      if (cursor_col >= cols || cursor_col == 0) begin
        cursor_col = '0;
        cursor_row = cursor_row + 1'b1;
        row_wrapped = (cursor_row == 0);
      end
      // frame ends once the row reaches the height (rollover counts as reaching it)
      if (row_wrapped || cursor_row >= rows) begin
        w.frame_done = 1'b1;
        cursor_col = '0;
        cursor_row = '0;
      end
      w.last = (k + 1 == run);
      pending_writes.push_back(w);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  // result side: random pop stalls in bursts
  always @(posedge clk) begin
    if (!idle_on) begin
      out_pop <= 1'b1;
    end else if (pop_hold > 0) begin
      out_pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_pop <= 1'b0;
      pop_hold = $urandom_range(0, 16);
    end else begin
      out_pop <= 1'b1;
    end
  end

  // check every result transfer against the oldest expected write
  always @(posedge clk) begin : check_writes
    cell_write_t got;
    cell_write_t want;
    if (rst_n && out_pop && !out_empty) begin
      got = '{out_cell_index, out_char_code, out_frame_done, out_last, out_halted};
      if (pending_writes.size() == 0) begin
        note_mismatch($sformatf("unexpected write: cell %0d char %02h done %0b last %0b halt %0b",
                                got.cell_index, got.char_code, got.frame_done, got.last,
                                got.halted));
      end else begin
        want = pending_writes.pop_front();
        if (got.cell_index !== want.cell_index || got.char_code !== want.char_code ||
            got.frame_done !== want.frame_done || got.last !== want.last ||
            got.halted !== want.halted) begin
          note_mismatch($sformatf({"write mismatch: expected cell %0d char %02h done %0b ",
                                   "last %0b halt %0b, got cell %0d char %02h done %0b ",
                                   "last %0b halt %0b"},
                                  want.cell_index, want.char_code, want.frame_done,
                                  want.last, want.halted, got.cell_index, got.char_code,
                                  got.frame_done, got.last, got.halted));
        end
      end
    end
  end

  // watchdog: cycles without any transfer or register write
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("FAILURE");
    $finish;
  end

  // one code byte transfer, with an optional gap before it
  task automatic push_code(input logic [rtfd_pkg::CODE_W-1:0] code);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_code_byte <= code;
    do @(posedge clk); while (in_full);
    expand_code(code);
  endtask

  // stop sending, wait for all expected writes, then let the block go quiet
  task automatic settle_idle();
    in_push <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // caller keeps cfg_we high when another write follows right away
  task automatic write_size_reg(input logic [rtfd_pkg::CFG_IDX_W-1:0] idx,
                                input logic [rtfd_pkg::CFG_DATA_W-1:0] data,
                                input bit hold_we);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    if (idx == rtfd_pkg::REG_COLUMNS) columns_reg = data;
    else if (idx == rtfd_pkg::REG_ROWS) rows_reg = data[rtfd_pkg::ROWS_W-1:0];
    if (!hold_we) cfg_we <= 1'b0;
  endtask

  task automatic set_screen(input int unsigned cols, input int unsigned rows);
    settle_idle();
    write_size_reg(rtfd_pkg::REG_COLUMNS, rtfd_pkg::CFG_DATA_W'(cols), 1'b1);
    write_size_reg(rtfd_pkg::REG_ROWS, rtfd_pkg::CFG_DATA_W'(rows), 1'b0);
  endtask

  // reset-size screen: every shade, short to longest runs
  task automatic test_default_screen();
    int s;
    for (s = 0; s < 8; s++) push_code(code_of(s * 4 + 1, s));
    push_code(code_of(31, 7));
    push_code(code_of(31, 0));
  endtask

  // smallest, largest and out-of-range sizes
  task automatic test_size_limits();
    // one column, full height: row counter rolls over at the last row
    set_screen(1, 64);
    repeat (3) push_code(code_of(31, 3));
    // full width, one row: column counter rolls over
    set_screen(128, 1);
    repeat (5) push_code(code_of(31, 6));
    // zero sizes act as one cell
    set_screen(0, 0);
    push_code(code_of(3, 2));
    // oversize values clamp to the maximum
    set_screen(255, 127);
    push_code(code_of(17, 5));
    set_screen(129, 65);
    push_code(code_of(9, 4));
  endtask

  // writes to indexes past the register list change nothing
  task automatic test_unused_index();
    settle_idle();
    write_size_reg(REG_SPARE2, rtfd_pkg::CFG_DATA_W'($urandom_range(0, 255)), 1'b1);
    write_size_reg(REG_SPARE3, rtfd_pkg::CFG_DATA_W'($urandom_range(0, 255)), 1'b0);
    push_code(code_of(12, 1));
    push_code(code_of(30, 2));
  endtask

  // shrink the screen under a cursor that sits outside the new size
  task automatic test_resize_mid_frame();
    set_screen(10, 8);
    push_code(code_of(31, 1));
    push_code(code_of(26, 2));
    set_screen(4, 3);
    push_code(code_of(4, 3));
    set_screen(100, 20);
    push_code(code_of(2, 7));
  endtask

  // random sizes per phase, random runs and shades
  task automatic test_random_frames();
    int          phase;
    int          n;
    int unsigned cols;
    int unsigned rows;
    int unsigned run;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 3))
        0: cols = $urandom_range(1, 8);
        1: cols = $urandom_range(0, 255);
        default: cols = $urandom_range(1, 128);
      endcase
      case ($urandom_range(0, 3))
        0: rows = $urandom_range(1, 4);
        1: rows = $urandom_range(0, 127);
        default: rows = $urandom_range(1, 64);
      endcase
      set_screen(cols, rows);
      // one phase runs with no stalls at all
      idle_on = (phase != 3);
      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(1, 31);
        push_code(code_of(run, $urandom_range(0, 7)));
      end
    end
  endtask

  // zero run stops the decoder; later bytes are dropped
  task automatic test_halt();
    idle_on = 1'b0;
    push_code(code_of($urandom_range(1, 31), $urandom_range(0, 7)));
    push_code(CODE_HALT);
    push_code(code_of(31, 7));
    push_code(code_of(0, 5));
    push_code(rtfd_pkg::CODE_W'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    idle_on = 1'b1;
    test_default_screen();
    test_size_limits();
    test_unused_index();
    test_resize_mid_frame();
    test_random_frames();
    test_halt();
    settle_idle();
    if (mismatches == 0 && pending_writes.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rtfd_pkg.sv
hw/rtl/rtfd_front.sv
hw/rtl/rtfd_cmd_fifo.sv
hw/rtl/rtfd_back.sv
hw/rtl/rle_text_frame_decoder.sv
dv/tb_rle_text_frame_decoder.sv
